@@ hdl/uudecode_stream_decoder_top_assert.svh @@
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef UUDECODE_STREAM_DECODER_TOP_ASSERT_SVH
`define UUDECODE_STREAM_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UUD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UUD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/uud_pkg.sv @@
package uud_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [5:0] MAX_LINE   = 6'd45;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SP      = 8'h20;
    localparam logic [7:0] CH_LEN_TOP = CH_SP + 8'(MAX_LINE);

    typedef enum logic [2:0] {
        PH_LEN  = 3'b001,
        PH_DATA = 3'b010,
        PH_SKIP = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_run;
    } out_item_t;

    // One decoded group: up to three bytes, count is 1 to 3.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ hdl/uudecode_stream_decoder_top.sv @@
// uuencode stream decoder. One text character is taken per transfer on the char
// channel and the decoded bytes leave one per transfer on the byte channel, the
// last byte produced by a character flagged with last_in_run. The input side
// takes one character every cycle; a complete group of four characters yields up
// to three bytes, which enter the queue with the fourth character and drain at
// one byte per cycle while byte_ready is high. Between the decoding front end
// and the output side sits a queue of QUEUE_DEPTH groups, so the input stalls
// only when that queue is full, which happens only while byte_ready is held low.
module uudecode_stream_decoder_top #(
    parameter int QUEUE_DEPTH = uud_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_ready,
    input  uud_pkg::in_item_t  char_item,
    output logic               byte_valid,
    input  logic               byte_ready,
    output uud_pkg::out_item_t byte_item
);

    logic             take;
    logic             push;
    logic             pop;
    uud_pkg::cmd_t    push_cmd;
    uud_pkg::cmd_t    head_cmd;
    uud_pkg::q_stat_t stat;

    assign char_ready = !stat.full;
    assign take       = char_valid && char_ready;

    uud_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (char_item),
        .push     (push),
        .push_cmd (push_cmd)
    );

    uud_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (stat)
    );

    uud_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .stat       (stat),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item)
    );

endmodule

@@ hdl/uud_fifo.sv @@
module uud_fifo #(
    parameter int DEPTH = uud_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  uud_pkg::cmd_t  push_cmd,
    input  logic           pop,
    output uud_pkg::cmd_t  head_cmd,
    output uud_pkg::q_stat_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [PW-1:0] PTR_ONE  = PW'(1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    uud_pkg::cmd_t      mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);

`include "uudecode_stream_decoder_top_assert.svh"

    `UUD_ASSERT_SAME(a_no_push_full, push, !stat.full || pop, "push into a full queue")
    `UUD_ASSERT_SAME(a_no_pop_empty, pop, !stat.empty, "pop from an empty queue")
    `UUD_ASSERT_NEXT(a_count_pop, pop && !push, count_reg == $past(count_reg) - CNT_ONE,
        "queue count did not fall after a pop")

endmodule

@@ hdl/uud_front.sv @@
module uud_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  uud_pkg::in_item_t item,
    output logic              push,
    output uud_pkg::cmd_t     push_cmd
);

    uud_pkg::phase_t phase_reg, phase_next;
    logic [5:0] line_length_reg, line_length_next;
    logic [5:0] bytes_done_reg, bytes_done_next;
    logic [1:0] group_pos_reg, group_pos_next;
    logic [2:0][5:0] group_reg;

    logic [7:0] ch;
    logic [7:0] ch_off;
    logic [5:0] v;
    logic [5:0] owed;
    logic [1:0] n;
    logic       group_full;
    logic       bad_len;

    assign ch         = item.char_in;
    assign ch_off     = ch - uud_pkg::CH_SP;
    assign v          = ch_off[5:0];
    assign owed       = line_length_reg - bytes_done_reg;
    assign n          = (owed < 6'd3) ? owed[1:0] : 2'd3;
    assign group_full = (group_pos_reg == 2'd3);
    assign bad_len    = (ch <= uud_pkg::CH_SP) || (ch > uud_pkg::CH_LEN_TOP);

    always_comb
    begin
        phase_next       = phase_reg;
        line_length_next = line_length_reg;
        bytes_done_next  = bytes_done_reg;
        group_pos_next   = group_pos_reg;
        push             = 1'b0;

        case (phase_reg)
            uud_pkg::PH_DATA:
            begin
                if (!group_full)
                begin
                    group_pos_next = group_pos_reg + 2'd1;
                end
                else
                begin
                    // The fourth character completes the group and releases its bytes.
                    push            = take && (n != 2'd0);
                    group_pos_next  = 2'd0;
                    bytes_done_next = bytes_done_reg + 6'(n);
                    if (bytes_done_next >= line_length_reg)
                    begin
                        phase_next = uud_pkg::PH_SKIP;
                    end
                end
            end
            uud_pkg::PH_SKIP:
            begin
                if (ch == uud_pkg::CH_NL)
                begin
                    phase_next = uud_pkg::PH_LEN;
                end
            end
            default:
            begin
                if (ch != uud_pkg::CH_NL)
                begin
                    bytes_done_next = '0;
                    group_pos_next  = '0;
                    if (bad_len)
                    begin
                        line_length_next = '0;
                        phase_next       = uud_pkg::PH_SKIP;
                    end
                    else
                    begin
                        line_length_next = v;
                        phase_next       = uud_pkg::PH_DATA;
                    end
                end
                else
                begin
                    phase_next = uud_pkg::PH_LEN;
                end
            end
        endcase

        if (item.end_of_message)
        begin
            phase_next       = uud_pkg::PH_LEN;
            line_length_next = '0;
            bytes_done_next  = '0;
            group_pos_next   = '0;
        end
    end

    assign push_cmd.bytes[0] = {group_reg[0], group_reg[1][5:4]};
    assign push_cmd.bytes[1] = {group_reg[1][3:0], group_reg[2][5:2]};
    assign push_cmd.bytes[2] = {group_reg[2][1:0], v};
    assign push_cmd.count    = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= uud_pkg::PH_LEN;
            line_length_reg <= '0;
            bytes_done_reg  <= '0;
            group_pos_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg       <= phase_next;
            line_length_reg <= line_length_next;
            bytes_done_reg  <= bytes_done_next;
            group_pos_reg   <= group_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && (phase_reg == uud_pkg::PH_DATA) && !group_full)
        begin
            group_reg[group_pos_reg] <= v;
        end
    end

`include "uudecode_stream_decoder_top_assert.svh"

    `UUD_ASSERT_SAME(a_owed_pos, phase_reg == uud_pkg::PH_DATA,
        bytes_done_reg < line_length_reg, "data phase with nothing owed")
    `UUD_ASSERT_SAME(a_len_range, 1'b1, line_length_reg <= uud_pkg::MAX_LINE,
        "line length beyond the maximum")
    `UUD_ASSERT_NEXT(a_eom_idle, take && item.end_of_message,
        phase_reg == uud_pkg::PH_LEN && group_pos_reg == 2'd0,
        "end of message did not return to idle")

endmodule

@@ hdl/uud_back.sv @@
module uud_back (
    input  logic               clk,
    input  logic               rst_n,
    input  uud_pkg::cmd_t      head_cmd,
    input  uud_pkg::q_stat_t   stat,
    output logic               pop,
    output logic               byte_valid,
    input  logic               byte_ready,
    output uud_pkg::out_item_t byte_item
);

    logic [1:0] idx_reg, idx_next;
    logic       last;

    assign byte_valid            = !stat.empty;
    assign last                  = (idx_reg == head_cmd.count - 2'd1);
    assign byte_item.data_byte   = head_cmd.bytes[idx_reg];
    assign byte_item.last_in_run = last;
    assign pop                   = byte_valid && byte_ready && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (byte_valid && byte_ready)
        begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

`include "uudecode_stream_decoder_top_assert.svh"

    `UUD_ASSERT_SAME(a_idx_range, byte_valid, idx_reg < head_cmd.count,
        "byte index beyond the group count")
    `UUD_ASSERT_SAME(a_idx_idle, !byte_valid, idx_reg == 2'd0,
        "byte index left mid-group with an empty queue")
    `UUD_ASSERT_SAME(a_pop_last, pop, byte_item.last_in_run,
        "queue popped before the last byte of a group")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    class uu_byte_scoreboard;
        uud_pkg::phase_t    line_phase;
        logic [5:0]         line_bytes;
        logic [5:0]         bytes_sent;
        logic [1:0]         group_pos;
        logic [5:0]         group_vals[3];
        uud_pkg::out_item_t expected_bytes[$];
        int                 errors;

        function new();
            line_phase = uud_pkg::PH_LEN;
            line_bytes = '0;
            bytes_sent = '0;
            group_pos  = '0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        task flag(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Advances the decoder state by one accepted character and queues the bytes it yields.
        task note_char(uud_pkg::in_item_t it);
            logic [7:0]         ch;
            logic [7:0]         diff;
            logic [5:0]         six;
            logic [7:0]         grp_bytes[3];
            int                 owed;
            int                 n;
            uud_pkg::out_item_t e;
            ch   = it.char_in;
            diff = ch - uud_pkg::CH_SP;
            six  = diff[5:0];
            case (line_phase)
                uud_pkg::PH_DATA:
                begin
                    if (group_pos < 2'd3)
                    begin
                        group_vals[group_pos] = six;
                        group_pos++;
                    end
                    else
                    begin
                        grp_bytes[0] = {group_vals[0], group_vals[1][5:4]};
                        grp_bytes[1] = {group_vals[1][3:0], group_vals[2][5:2]};
                        grp_bytes[2] = {group_vals[2][1:0], six};
                        owed = int'(line_bytes) - int'(bytes_sent);
                        n = (owed < 3) ? owed : 3;
                        for (int k = 0; k < n; k++)
                        begin
                            e.data_byte   = grp_bytes[k];
                            e.last_in_run = (k == n - 1);
                            expected_bytes.push_back(e);
                        end
                        bytes_sent = bytes_sent + 6'(n);
                        group_pos  = '0;
                        if (bytes_sent >= line_bytes)
                            line_phase = uud_pkg::PH_SKIP;
                    end
                end
                uud_pkg::PH_SKIP:
                begin
                    if (ch == uud_pkg::CH_NL)
                        line_phase = uud_pkg::PH_LEN;
                end
                default:
                begin
                    if (ch != uud_pkg::CH_NL)
                    begin
                        bytes_sent = '0;
                        group_pos  = '0;
                        if (ch <= uud_pkg::CH_SP || ch > uud_pkg::CH_LEN_TOP)
                        begin
                            line_bytes = '0;
                            line_phase = uud_pkg::PH_SKIP;
                        end
                        else
                        begin
                            line_bytes = diff[5:0];
                            line_phase = uud_pkg::PH_DATA;
                        end
                    end
                    else
                        line_phase = uud_pkg::PH_LEN;
                end
            endcase
            if (it.end_of_message)
            begin
                line_phase = uud_pkg::PH_LEN;
                line_bytes = '0;
                bytes_sent = '0;
                group_pos  = '0;
            end
        endtask

        task check_byte(uud_pkg::out_item_t got);
            uud_pkg::out_item_t want;
            if (expected_bytes.size() == 0)
            begin
                flag($sformatf("unexpected byte %02h last %b",
                               got.data_byte, got.last_in_run));
                return;
            end
            want = expected_bytes.pop_front();
            if (got.data_byte !== want.data_byte)
                flag($sformatf("data_byte %02h, expected %02h", got.data_byte, want.data_byte));
            if (got.last_in_run !== want.last_in_run)
                flag($sformatf("last_in_run %b, expected %b on byte %02h",
                               got.last_in_run, want.last_in_run, want.data_byte));
        endtask
    endclass

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               char_valid = 1'b0;
    logic               char_ready;
    uud_pkg::in_item_t  char_item  = '0;
    logic               byte_valid;
    logic               byte_ready = 1'b0;
    uud_pkg::out_item_t byte_item;

    int sender_idle_pct   = 13;
    int receiver_idle_pct = 47;
    int chars_sent        = 0;

    uu_byte_scoreboard sb = new();

    uudecode_stream_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        byte_ready <= ($urandom_range(99) >= receiver_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_valid && char_ready)
                sb.note_char(char_item);
            if (byte_valid && byte_ready)
                sb.check_byte(byte_item);
        end
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Valid is left high after a transfer so that back-to-back characters need no gap.
    task send_char(logic [7:0] ch, logic eom);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_item  <= '{char_in: ch, end_of_message: eom};
        char_valid <= 1'b1;
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        chars_sent++;
    endtask

    task wait_drained();
        char_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function logic rand_eom();
        return ($urandom_range(79) == 0);
    endfunction

    task send_random_line();
        int kind;
        int len;
        int nchars;
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(1) ? 45 : $urandom_range(30, 45);
            else
                len = $urandom_range(1, 12);
            send_char(uud_pkg::CH_SP + 8'(len), rand_eom());
            nchars = ((len + 2) / 3) * 4;
            for (int i = 0; i < nchars; i++)
                send_char($urandom_range(4) == 0 ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(32, 95)), rand_eom());
            // Trailing junk is skipped along with the rest of the line.
            if ($urandom_range(3) == 0)
                send_char(8'($urandom_range(255)), rand_eom());
            send_char(uud_pkg::CH_NL, rand_eom());
        end
        else if (kind < 88)
        begin
            // Truncated line: newlines inside the data are taken as data characters.
            len = $urandom_range(1, 45);
            send_char(uud_pkg::CH_SP + 8'(len), rand_eom());
            nchars = $urandom_range(0, 7);
            for (int i = 0; i < nchars; i++)
                send_char(8'($urandom_range(32, 95)), rand_eom());
            send_char(uud_pkg::CH_NL, rand_eom());
        end
        else
        begin
            nchars = $urandom_range(1, 4);
            for (int i = 0; i < nchars; i++)
                send_char(8'($urandom_range(255)), rand_eom());
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A newline while waiting for a length is ignored.
        send_char(uud_pkg::CH_NL, 1'b0);
        // Length 3 with data characters at both extremes, including ones that wrap into six bits.
        send_char(8'h23, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h60, 1'b0);
        send_char(uud_pkg::CH_SP, 1'b0);
        send_char(uud_pkg::CH_NL, 1'b0);
        // Lengths below the space, above the top and of zero all skip the line.
        send_char(8'h1F, 1'b0);
        send_char(uud_pkg::CH_NL, 1'b0);
        send_char(8'h4E, 1'b0);
        send_char(uud_pkg::CH_NL, 1'b0);
        send_char(uud_pkg::CH_SP, 1'b0);
        send_char(uud_pkg::CH_NL, 1'b0);
        // Length 2 whose data characters are all newlines.
        send_char(8'h22, 1'b0);
        repeat (5) send_char(uud_pkg::CH_NL, 1'b0);
        // End of message in the middle of a group, then on a length character.
        send_char(8'h24, 1'b0);
        send_char(8'h41, 1'b0);
        send_char(8'h42, 1'b1);
        send_char(8'h21, 1'b1);
        // Length 1, with the message ending on the character that completes the group.
        send_char(8'h21, 1'b0);
        send_char(8'h3F, 1'b0);
        send_char(8'h5F, 1'b0);
        send_char(8'h30, 1'b0);
        send_char(8'h55, 1'b1);
        wait_drained();

        while (chars_sent < 160)
            send_random_line();
        wait_drained();

        sender_idle_pct   = 47;
        receiver_idle_pct = 13;
        while (chars_sent < 280)
            send_random_line();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        while (chars_sent < 405)
            send_random_line();

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
